// ----- rtl/core/gsge_pkg.sv -----
// Shared types, constants and a helper function of the genetic search generation engine.
package gsge_pkg;

  // Default sizing handed to the top-level parameters
  localparam int POPULATION_SIZE_DEF = 128;
  localparam int GENOME_BITS_DEF     = 64;

  // Fixed field widths
  localparam int GENOME_W    = 64;
  localparam int INDEX_W     = 7;
  localparam int INDEX_RANGE = 2 ** INDEX_W;
  localparam int FIT_W       = 7;
  localparam int DRAW_W      = 16;
  localparam int GEN_W       = 10;
  localparam int STATUS_W    = 2;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSSOVER_RATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION_LIMIT = 1'b1;
  localparam logic [DRAW_W-1:0]    CROSSOVER_RATE_RST   = 16'd64225;
  localparam logic [GEN_W-1:0]     GENERATION_LIMIT_RST = 10'd100;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_BREED = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_LOADED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHILD    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_GEN_DONE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [INDEX_W-1:0]  slot;
    logic [GENOME_W-1:0] genome_in;
    logic [INDEX_W-1:0]  first_a;
    logic [INDEX_W-1:0]  first_b;
    logic [INDEX_W-1:0]  second_a;
    logic [INDEX_W-1:0]  second_b;
    logic [DRAW_W-1:0]   cross_draw;
    logic [INDEX_W-1:0]  cut_point;
    logic [GENOME_W-1:0] flip_mask;
  } gsge_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GENOME_W-1:0] child_genome;
    logic [FIT_W-1:0]    child_fitness;
    logic [FIT_W-1:0]    best_fitness;
    logic [GENOME_W-1:0] best_genome;
    logic [GEN_W-1:0]    generation;
    logic                finished;
  } gsge_out_t;

  // Which tournament contestant the store read fetches
  typedef enum logic [1:0] {
    SEL_FIRST_A,
    SEL_FIRST_B,
    SEL_SECOND_A,
    SEL_SECOND_B
  } contest_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         capture;
    logic         rd_en;
    contest_sel_t rd_sel;
    logic         take_cand;
    logic         pick1;
    logic         pick2;
    logic         make_child;
    logic         commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_breed;
    logic out_free;
  } dp_sts_t;

  // Ones count as a six-level adder tree
  function automatic logic [FIT_W-1:0] ones_count(logic [GENOME_W-1:0] v);
    logic [FIT_W-1:0] acc [GENOME_W];
    for (int i = 0; i < GENOME_W; i++) begin
      acc[i] = FIT_W'(v[i]);
    end
    for (int lvl = 0; lvl < 6; lvl++) begin
      for (int i = 0; i < ((GENOME_W / 2) >> lvl); i++) begin
        acc[i] = acc[2*i] + acc[2*i+1];
      end
    end
    return acc[0];
  endfunction

endpackage

// ----- rtl/core/gsge_ctrl.sv -----
// Sequencing state machine of the genetic search generation engine.
module gsge_ctrl
  import gsge_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_RD_D,
    S_PICK2,
    S_MIX,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.go_breed ? S_RD_A : S_COMMIT;
        end
      end
      S_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_FIRST_A;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = SEL_FIRST_B;
        cmd.take_cand = 1'b1;
        state_nxt     = S_RD_C;
      end
      S_RD_C: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_SECOND_A;
        cmd.pick1  = 1'b1;
        state_nxt  = S_RD_D;
      end
      S_RD_D: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = SEL_SECOND_B;
        cmd.take_cand = 1'b1;
        state_nxt     = S_PICK2;
      end
      S_PICK2: begin
        cmd.pick2 = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.make_child = 1'b1;
        state_nxt      = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register can take the transaction
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/gsge_datapath.sv -----
// Genome store, tournaments, crossover, mutation and search bookkeeping.
module gsge_datapath
  import gsge_pkg::*;
#(
  parameter int POPULATION_SIZE = POPULATION_SIZE_DEF,
  parameter int GENOME_BITS     = GENOME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gsge_in_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gsge_out_t             out_data
);

  localparam int IDX_W = $clog2(POPULATION_SIZE);
  localparam int DEPTH = 2 * POPULATION_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]    BANK_OFS  = AW'(POPULATION_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POPULATION_SIZE - 1);
  localparam logic [FIT_W-1:0] FULL_FIT  = FIT_W'(GENOME_BITS);

  typedef logic [INDEX_RANGE-1:0][IDX_W-1:0] mod_tbl_t;

  // Index field reduced modulo the population size, built at elaboration
  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    for (int i = 0; i < INDEX_RANGE; i++) begin
      t[i] = IDX_W'(i % POPULATION_SIZE);
    end
    return t;
  endfunction

  localparam mod_tbl_t MOD_TBL = build_mod_tbl();

  logic [GENOME_BITS-1:0] mem [DEPTH];

  gsge_in_t               in_r;
  logic [DRAW_W-1:0]      crossover_rate_r;
  logic [GEN_W-1:0]       generation_limit_r;
  logic                   live_bank_r, live_bank_nxt;
  logic [IDX_W-1:0]       children_made_r, children_made_nxt;
  logic [FIT_W-1:0]       best_score_r, best_score_nxt;
  logic [GENOME_BITS-1:0] best_bits_r, best_bits_nxt;
  logic [GEN_W-1:0]       generations_done_r, generations_done_nxt;
  logic                   search_over_r, search_over_nxt;
  logic [GENOME_BITS-1:0] rdata_r;
  logic [GENOME_BITS-1:0] cand_genome_r;
  logic [FIT_W-1:0]       cand_fit_r;
  logic [GENOME_BITS-1:0] p1_r, p2_r, child_r;
  logic                   out_valid_r;
  gsge_out_t              out_data_r;

  logic [INDEX_W-1:0]     rd_index;
  logic [IDX_W-1:0]       rd_idx;
  logic [AW-1:0]          rd_addr;
  logic [FIT_W-1:0]       rd_fit;
  logic [GENOME_BITS-1:0] winner;
  logic [GENOME_BITS-1:0] low_mask;
  logic [GENOME_BITS-1:0] mixed;
  logic [FIT_W-1:0]       child_fit;
  logic                   slot_in_range;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [GENOME_BITS-1:0] mem_wdata;
  gsge_out_t              res;

  assign sts.go_breed = (in_data.kind == KIND_BREED) && !search_over_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // Contestant read address in the live bank
  always_comb begin
    unique case (cmd.rd_sel)
      SEL_FIRST_A:  rd_index = in_r.first_a;
      SEL_FIRST_B:  rd_index = in_r.first_b;
      SEL_SECOND_A: rd_index = in_r.second_a;
      SEL_SECOND_B: rd_index = in_r.second_b;
      default:      rd_index = in_r.first_a;
    endcase
    rd_idx  = MOD_TBL[rd_index];
    rd_addr = live_bank_r ? (BANK_OFS + AW'(rd_idx)) : AW'(rd_idx);
  end

  // Tournament: the second contestant wins ties
  assign rd_fit = ones_count(GENOME_W'(rdata_r));
  assign winner = (cand_fit_r > rd_fit) ? cand_genome_r : rdata_r;

  // One-point crossover; mutation is applied when the child is registered
  always_comb begin
    for (int i = 0; i < GENOME_BITS; i++) begin
      low_mask[i] = (in_r.cut_point > INDEX_W'(i));
    end
    if (in_r.cross_draw > crossover_rate_r) begin
      mixed = p1_r;
    end else begin
      mixed = (p1_r & low_mask) | (p2_r & ~low_mask);
    end
  end

  assign child_fit     = ones_count(GENOME_W'(child_r));
  assign slot_in_range = ({25'd0, in_r.slot} < 32'(POPULATION_SIZE));

  // Result and bookkeeping of the committed item
  always_comb begin
    live_bank_nxt        = live_bank_r;
    children_made_nxt    = children_made_r;
    best_score_nxt       = best_score_r;
    best_bits_nxt        = best_bits_r;
    generations_done_nxt = generations_done_r;
    search_over_nxt      = search_over_r;
    mem_we               = 1'b0;
    mem_waddr            = live_bank_r ? (BANK_OFS + AW'(MOD_TBL[in_r.slot]))
                                       : AW'(MOD_TBL[in_r.slot]);
    mem_wdata            = in_r.genome_in[GENOME_BITS-1:0];
    res                  = '0;
    if (cmd.commit) begin
      priority if (in_r.kind == KIND_LOAD) begin
        mem_we     = slot_in_range;
        res.status = STATUS_LOADED;
      end else if (search_over_r) begin
        res.status = STATUS_REFUSED;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = live_bank_r ? AW'(children_made_r)
                                : (BANK_OFS + AW'(children_made_r));
        mem_wdata = child_r;
        if (child_fit > best_score_r) begin
          best_score_nxt = child_fit;
          best_bits_nxt  = child_r;
        end
        if (children_made_r == LAST_IDX) begin
          children_made_nxt    = '0;
          live_bank_nxt        = !live_bank_r;
          generations_done_nxt = generations_done_r + GEN_W'(1);
          search_over_nxt      = (best_score_nxt == FULL_FIT) ||
                                 (generations_done_nxt >= generation_limit_r);
          res.status           = STATUS_GEN_DONE;
        end else begin
          children_made_nxt = children_made_r + IDX_W'(1);
          res.status        = STATUS_CHILD;
        end
        res.child_genome  = GENOME_W'(child_r);
        res.child_fitness = child_fit;
      end
    end
    res.best_fitness = best_score_nxt;
    res.best_genome  = GENOME_W'(best_bits_nxt);
    res.generation   = generations_done_nxt;
    res.finished     = search_over_nxt;
  end

  // Genome store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.take_cand) begin
      cand_genome_r <= rdata_r;
      cand_fit_r    <= rd_fit;
    end
    if (cmd.pick1) begin
      p1_r <= winner;
    end
    if (cmd.pick2) begin
      p2_r <= winner;
    end
    if (cmd.make_child) begin
      child_r <= mixed ^ in_r.flip_mask[GENOME_BITS-1:0];
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crossover_rate_r   <= CROSSOVER_RATE_RST;
      generation_limit_r <= GENERATION_LIMIT_RST;
      live_bank_r        <= 1'b0;
      children_made_r    <= '0;
      best_score_r       <= '0;
      best_bits_r        <= '0;
      generations_done_r <= '0;
      search_over_r      <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CROSSOVER_RATE:   crossover_rate_r   <= cfg_data;
          CFG_GENERATION_LIMIT: generation_limit_r <= cfg_data[GEN_W-1:0];
          default: ;
        endcase
      end
      live_bank_r        <= live_bank_nxt;
      children_made_r    <= children_made_nxt;
      best_score_r       <= best_score_nxt;
      best_bits_r        <= best_bits_nxt;
      generations_done_r <= generations_done_nxt;
      search_over_r      <= search_over_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/genetic_search_generation_engine_top.sv -----
// Top level of the genetic search generation engine (OneMax with tournament breeding).
// A breed item steps through four contestant reads through the single read port of the
// genome store with both tournaments, then crossover with mutation and commit; a load or a refused
// breed goes straight to commit. A new item is taken only after the last one has committed.
// Reset: rst_n is synchronous and active low; it clears control, counters, best and config.
// The genome store is not cleared: no clearing pass, items are taken right after reset.
module genetic_search_generation_engine_top
  import gsge_pkg::*;
#(
  parameter int POPULATION_SIZE = POPULATION_SIZE_DEF,
  parameter int GENOME_BITS     = GENOME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions: loads and breed requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gsge_in_t              in_data,
  // result transactions: one per input item
  output logic                  out_valid,
  input  logic                  out_ready,
  output gsge_out_t             out_data,
  // configuration writes, to be made only while the engine is idle; the block does not enforce it
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: accept one item, step the store reads of a breed, then commit the result
  gsge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: genome store, tournaments, crossover, mutation, best tracking
  // and the output register that holds a result until it is taken
  gsge_datapath #(
    .POPULATION_SIZE (POPULATION_SIZE),
    .GENOME_BITS     (GENOME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/gsge_checker.sv -----
// Port-level checker of the genetic search generation engine and its bind.
module gsge_checker
  import gsge_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input gsge_out_t out_data
);

  // one item at a time: ready drops right after an accepted transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is still in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a refusal only comes from a finished search and carries no child
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_REFUSED) |->
      out_data.finished && (out_data.child_genome == '0) && (out_data.child_fitness == '0))
    else $error("bad refusal result");

  // a stored child never beats the running best
  a_best_covers_child: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == STATUS_CHILD) || (out_data.status == STATUS_GEN_DONE)) |->
      (out_data.child_fitness <= out_data.best_fitness))
    else $error("child fitness above best fitness");

  // loads carry no child
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_LOADED) |->
      (out_data.child_genome == '0) && (out_data.child_fitness == '0))
    else $error("load result carries a child");

endmodule

bind genetic_search_generation_engine_top gsge_checker u_gsge_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
